// ===== rtl/dca_pkg.sv =====
package dca_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int CHAN_W = 4;
    localparam int DATA_W = 32;
    localparam int IRQ_BITS = 7;
    localparam logic [15:0] REQ_RESET = 16'h3400;

    typedef enum logic [2:0] {
        OP_SET_REQ   = 3'd0,
        OP_CLR_REQ   = 3'd1,
        OP_WR_CTRL   = 3'd2,
        OP_RD_CTRL   = 3'd3,
        OP_XFER_END  = 3'd4,
        OP_WR_IRQ    = 3'd5,
        OP_RD_IRQ    = 3'd6,
        OP_UNUSED    = 3'd7
    } op_t;

    typedef struct packed {
        logic       unk30;
        logic       busy;
        logic [1:0] sync;
        logic       unk8;
        logic       dir;
    } ctrl_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [CHAN_W-1:0] channel;
        logic              bank;
        logic [DATA_W-1:0] wdata;
    } event_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              active_valid;
        logic [CHAN_W-1:0] active_chan;
        logic              irq_raise;
    } result_t;

    function automatic logic [DATA_W-1:0] ctrl_to_word(input ctrl_t c);
        logic [DATA_W-1:0] w;
        w       = '0;
        w[0]    = c.dir;
        w[8]    = c.unk8;
        w[10:9] = c.sync;
        w[24]   = c.busy;
        w[30]   = c.unk30;
        return w;
    endfunction

    function automatic ctrl_t word_to_ctrl(input logic [DATA_W-1:0] v);
        ctrl_t c;
        c.dir   = v[0];
        c.unk8  = v[8];
        c.sync  = v[10:9];
        c.busy  = v[24];
        c.unk30 = v[30];
        return c;
    endfunction

    function automatic logic [DATA_W-1:0] irq_word(
        input logic                force_bit,
        input logic [IRQ_BITS-1:0] mask,
        input logic                enable,
        input logic [IRQ_BITS-1:0] status
    );
        logic [DATA_W-1:0] w;
        w        = '0;
        w[15]    = force_bit;
        w[22:16] = mask;
        w[23]    = enable;
        w[30:24] = status;
        w[31]    = enable && ((mask & status) != '0);
        return w;
    endfunction

endpackage

// ===== rtl/dca_prio.sv =====
module dca_prio #(
    parameter int NUM_CHANNELS = dca_pkg::NUM_CHANNELS_DEF
) (
    input  logic [NUM_CHANNELS-1:0]   eligible,
    output logic                      found,
    output logic [dca_pkg::CHAN_W-1:0] chan
);
    import dca_pkg::*;

    always_comb
    begin
        found = 1'b0;
        chan  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (eligible[i])
            begin
                found = 1'b1;
                chan  = CHAN_W'(i);
            end
        end
    end

endmodule

// ===== rtl/dca_state.sv =====
module dca_state #(
    parameter int NUM_CHANNELS = dca_pkg::NUM_CHANNELS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  dca_pkg::event_t  ev,
    output dca_pkg::result_t res
);
    import dca_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [NUM_CHANNELS-1:0] request_reg;
    logic [NUM_CHANNELS-1:0] request_next;
    ctrl_t                   ctrl_reg [NUM_CHANNELS];
    ctrl_t                   ctrl_next [NUM_CHANNELS];
    logic [IRQ_BITS-1:0]     mask_reg [2];
    logic [IRQ_BITS-1:0]     mask_next [2];
    logic [IRQ_BITS-1:0]     status_reg [2];
    logic [IRQ_BITS-1:0]     status_next [2];
    logic [1:0]              enable_reg;
    logic [1:0]              enable_next;
    logic [1:0]              force_reg;
    logic [1:0]              force_next;

    logic                    ch_ok;
    logic [IDX_W-1:0]        idx;
    logic                    end_bank;
    logic [2:0]              end_bit;
    logic [7:0]              end_mask;
    logic [NUM_CHANNELS-1:0] eligible;
    logic                    found;
    logic [CHAN_W-1:0]       found_chan;
    logic [DATA_W-1:0]       rd_data;
    logic                    irq_hit;

    assign ch_ok    = ({1'b0, ev.channel} < (CHAN_W + 1)'(NUM_CHANNELS));
    assign idx      = ev.channel[IDX_W-1:0];
    assign end_bank = ev.channel[CHAN_W-1];
    assign end_bit  = ev.channel[2:0];
    assign end_mask = {1'b0, mask_reg[end_bank]};

    always_comb
    begin
        request_next = request_reg;
        ctrl_next    = ctrl_reg;
        mask_next    = mask_reg;
        status_next  = status_reg;
        enable_next  = enable_reg;
        force_next   = force_reg;
        rd_data      = '0;
        irq_hit      = 1'b0;
        case (ev.op)
            OP_SET_REQ:
            begin
                if (ch_ok)
                    request_next[idx] = 1'b1;
            end
            OP_CLR_REQ:
            begin
                if (ch_ok)
                    request_next[idx] = 1'b0;
            end
            OP_WR_CTRL:
            begin
                if (ch_ok)
                    ctrl_next[idx] = word_to_ctrl(ev.wdata);
            end
            OP_RD_CTRL:
            begin
                if (ch_ok)
                    rd_data = ctrl_to_word(ctrl_reg[idx]);
            end
            OP_XFER_END:
            begin
                if (ch_ok)
                begin
                    ctrl_next[idx].busy = 1'b0;
                    if (end_mask[end_bit])
                    begin
                        status_next[end_bank][end_bit] = 1'b1;
                        irq_hit = 1'b1;
                    end
                end
            end
            OP_WR_IRQ:
            begin
                force_next[ev.bank]  = ev.wdata[15];
                mask_next[ev.bank]   = ev.wdata[22:16];
                enable_next[ev.bank] = ev.wdata[23];
                status_next[ev.bank] = status_reg[ev.bank] & ~ev.wdata[30:24];
                irq_hit              = ev.wdata[15];
            end
            OP_RD_IRQ:
            begin
                rd_data = irq_word(force_reg[ev.bank], mask_reg[ev.bank],
                                   enable_reg[ev.bank], status_reg[ev.bank]);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
            eligible[i] = request_next[i] && ctrl_next[i].busy;
    end

    dca_prio #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_prio (
        .eligible(eligible),
        .found   (found),
        .chan    (found_chan)
    );

    assign res = {rd_data, found, found_chan, irq_hit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_reg <= REQ_RESET[NUM_CHANNELS-1:0];
            for (int i = 0; i < NUM_CHANNELS; i++)
                ctrl_reg[i] <= '0;
            for (int b = 0; b < 2; b++)
            begin
                mask_reg[b]   <= '0;
                status_reg[b] <= '0;
            end
            enable_reg <= '0;
            force_reg  <= '0;
        end
        else if (fire)
        begin
            request_reg <= request_next;
            ctrl_reg    <= ctrl_next;
            mask_reg    <= mask_next;
            status_reg  <= status_next;
            enable_reg  <= enable_next;
            force_reg   <= force_next;
        end
    end

endmodule

// ===== rtl/dma_channel_arbiter_irq_unit.sv =====
// Pipeline: an accepted request waits in the request register and its result is registered in the
// result register. Throughput: one request per cycle unless the output stalls; the event logic and
// 16-bit priority encoder sit between the request register and the result register.
// Reset: asynchronous, active low; requests for channels 10, 12 and 13 are set,
// all control and interrupt words are cleared, and both pipeline stages are empty.
module dma_channel_arbiter_irq_unit #(
    parameter int NUM_CHANNELS = dca_pkg::NUM_CHANNELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  op,
    input  logic [dca_pkg::CHAN_W-1:0]  channel,
    input  logic                        bank,
    input  logic [dca_pkg::DATA_W-1:0]  wdata,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dca_pkg::DATA_W-1:0]  rdata,
    output logic                        active_valid,
    output logic [dca_pkg::CHAN_W-1:0]  active_chan,
    output logic                        irq_raise
);
    import dca_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    event_t  ev_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res;
    logic    out_free;
    logic    fire;
    logic    take_in;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign take_in  = in_valid && !in_stall;

    assign in_valid_next  = take_in || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    dca_state #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_state (
        .clk  (clk),
        .rst_n(rst_n),
        .fire (fire),
        .ev   (ev_reg),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            ev_reg.op      <= op;
            ev_reg.channel <= channel;
            ev_reg.bank    <= bank;
            ev_reg.wdata   <= wdata;
        end
        if (fire)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign rdata        = res_reg.rdata;
    assign active_valid = res_reg.active_valid;
    assign active_chan  = res_reg.active_chan;
    assign irq_raise    = res_reg.irq_raise;

    a_idle_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active_valid |-> active_chan == '0)
        else $error("active channel nonzero with no eligible channel");

    a_irq_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_raise |-> rdata == '0)
        else $error("interrupt raised on a read request");

    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && active_valid |-> {1'b0, active_chan} < (CHAN_W + 1)'(NUM_CHANNELS))
        else $error("active channel out of range");

    a_fire_empties: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !take_in |=> !in_valid_reg && out_valid_reg)
        else $error("pipeline bookkeeping lost a request");

endmodule
